@@ design/palt_pkg.sv @@
package palt_pkg;

    // Field widths
    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_WIDTH  = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((6 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;

    // Configuration register map
    localparam int NUM_REGS      = 7;
    localparam int CFG_IDX_WIDTH = $clog2(NUM_REGS);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_BASE_X,
        REG_BASE_Y,
        REG_BASE_ANGLE,
        REG_START_X,
        REG_START_Y,
        REG_END_X,
        REG_END_Y
    } cfg_reg_t;

    localparam int START_X_RST = 2560;
    localparam int END_X_RST   = 2560;
    localparam int END_Y_RST   = 10240;

    // Angle wrap: one turn in 1/64 degree units
    localparam int TURN_UNITS  = 23040;
    localparam int DIFF_WIDTH  = 18;                 // difference plus three turns
    localparam int TURN_OFFSET = 3 * TURN_UNITS;
    localparam int MAX_WRAPS   = 5;
    localparam int DEG_WIDTH   = 15;                 // wrapped angle 0..TURN_UNITS-1

    // Binary angle: b = q*2^23 + seg_bam(r) with d = 45*q + r
    localparam int SEG_UNITS        = 45;
    localparam int RECIP_SEG        = 23302;         // ceil(2^20 / 45)
    localparam int RECIP_SHIFT      = 20;
    localparam int RECIP_PROD_WIDTH = 30;
    localparam int QSEG_WIDTH       = 9;
    localparam int REM_WIDTH        = 6;
    localparam int BAM_LOW_WIDTH    = 23;
    localparam int BAM_PER_REM      = 186413;        // floor(2^23 / 45)
    localparam int BAM_WIDTH        = 32;

    // CORDIC
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_WIDTH = 34;
    localparam int CORDIC_X0    = 652032874;
    localparam int TRIG_WIDTH   = 17;                // Q1.15 plus headroom for negation

    typedef struct packed {
        logic                     pvalid;
        logic [COORD_WIDTH-1:0]   x;
        logic [COORD_WIDTH-1:0]   y;
        logic [ANGLE_WIDTH-1:0]   ang;
    } pose_t;

    typedef struct packed {
        logic                     na;
        logic [COORD_WIDTH-1:0]   sx;
        logic [COORD_WIDTH-1:0]   sy;
        logic [COORD_WIDTH-1:0]   ex;
        logic [COORD_WIDTH-1:0]   ey;
        logic [COORD_WIDTH-1:0]   px;
        logic [COORD_WIDTH-1:0]   py;
        logic [ANGLE_WIDTH-1:0]   pa;
    } res_t;

    // Arctangent of 2^-i as a 32-bit binary angle
    function automatic logic signed [CORDIC_WIDTH-1:0] atan_step(input int step);
        case (step)
            0:       return CORDIC_WIDTH'(536870912);
            1:       return CORDIC_WIDTH'(316933406);
            2:       return CORDIC_WIDTH'(167458907);
            3:       return CORDIC_WIDTH'(85004756);
            4:       return CORDIC_WIDTH'(42667331);
            5:       return CORDIC_WIDTH'(21354465);
            6:       return CORDIC_WIDTH'(10679838);
            7:       return CORDIC_WIDTH'(5340245);
            8:       return CORDIC_WIDTH'(2670163);
            9:       return CORDIC_WIDTH'(1335087);
            10:      return CORDIC_WIDTH'(667544);
            11:      return CORDIC_WIDTH'(333772);
            12:      return CORDIC_WIDTH'(166886);
            13:      return CORDIC_WIDTH'(83443);
            14:      return CORDIC_WIDTH'(41722);
            15:      return CORDIC_WIDTH'(20861);
            16:      return CORDIC_WIDTH'(10430);
            17:      return CORDIC_WIDTH'(5215);
            18:      return CORDIC_WIDTH'(2608);
            19:      return CORDIC_WIDTH'(1304);
            default: return '0;
        endcase
    endfunction

    // Low bits of the binary angle for a remainder r in 0..44:
    // floor((r * 2^23 + 22) / 45) = r * 186413 + ceil(r / 2)
    function automatic logic [BAM_LOW_WIDTH-1:0] seg_bam(input logic [REM_WIDTH-1:0] rem);
        return BAM_LOW_WIDTH'(rem) * BAM_LOW_WIDTH'(BAM_PER_REM)
             + BAM_LOW_WIDTH'((rem + REM_WIDTH'(1)) >> 1);
    endfunction

endpackage

@@ design/pose_aligned_line_transform.sv @@
// Channel  | Ports                       | Beat contents
// ---------+-----------------------------+---------------------------------------------
// s_       | tvalid tready tdata tuser   | one pose: tuser = pose_valid, tdata = x,y,ang
// m_       | tvalid tready tdata tuser   | one mapped line: tuser = not_available
// cfg_     | wr_en index wdata           | register write, no read-back
//
// One beat per cycle sustained while the skid is empty; the path to m_tvalid runs through
// the angle wrap and binary-angle front end, 20-stage CORDIC chain and multiply tail.
// Synchronous active-low reset clears all valids and loads register defaults.
// The pipeline advances as one; a two-entry output (register plus skid) takes the beat
// leaving the last stage, so s_tready drops only once the skid entry is full.
module pose_aligned_line_transform (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [palt_pkg::IN_DATA_WIDTH-1:0]  s_tdata,   // pose_x, pose_y, pose_angle
    input  logic                                s_tuser,   // pose_valid
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [palt_pkg::OUT_DATA_WIDTH-1:0] m_tdata,   // out_start_x, out_start_y,
                                                           // out_end_x, out_end_y,
                                                           // echo_x, echo_y, echo_angle
    output logic                                m_tuser,   // not_available
    input  logic                                cfg_wr_en,
    input  logic [palt_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [palt_pkg::COORD_WIDTH-1:0]    cfg_wdata
);
    import palt_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int NSTG    = 29;
    localparam int ST_LAST = NSTG - 1;
    localparam int TW      = CW + 1;                 // endpoint minus baseline
    localparam int PW      = TW + TRIG_WIDTH;        // one product
    localparam int SW      = PW + 1;                 // sum of two products
    localparam int RW      = SW - 15;                // rotated offset after rounding
    localparam int OW      = RW + 1;                 // pose plus offset

    localparam logic signed [CORDIC_WIDTH-1:0] Q15_HALF = CORDIC_WIDTH'(1 << 14);
    localparam logic signed [CORDIC_WIDTH-1:0] TRIG_MAX = CORDIC_WIDTH'(32767);
    localparam logic signed [CORDIC_WIDTH-1:0] TRIG_MIN = -CORDIC_WIDTH'(32768);
    localparam logic signed [SW-1:0]           ROT_HALF = SW'(1 << 14);
    localparam logic signed [OW-1:0]           COORD_MAX = OW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [OW-1:0]           COORD_MIN = ~COORD_MAX;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    function automatic logic signed [TRIG_WIDTH-1:0] q15_round(
        input logic signed [CORDIC_WIDTH-1:0] v
    );
        logic signed [CORDIC_WIDTH-1:0] t;
        t = (v + Q15_HALF) >>> 15;
        if (t > TRIG_MAX) begin
            t = TRIG_MAX;
        end else if (t < TRIG_MIN) begin
            t = TRIG_MIN;
        end
        return TRIG_WIDTH'(t);
    endfunction

    function automatic logic [CW-1:0] sat_coord(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] t;
        t = v;
        if (t > COORD_MAX) begin
            t = COORD_MAX;
        end else if (t < COORD_MIN) begin
            t = COORD_MIN;
        end
        return CW'(t);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0]          base_x_reg, base_y_reg;
    logic [ANGLE_WIDTH-1:0] base_ang_reg;
    logic [CW-1:0]          start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_x_reg   <= '0;
            base_y_reg   <= '0;
            base_ang_reg <= '0;
            start_x_reg  <= CW'(START_X_RST);
            start_y_reg  <= '0;
            end_x_reg    <= CW'(END_X_RST);
            end_y_reg    <= CW'(END_Y_RST);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_X:     base_x_reg   <= cfg_wdata;
                REG_BASE_Y:     base_y_reg   <= cfg_wdata;
                REG_BASE_ANGLE: base_ang_reg <= cfg_wdata[ANGLE_WIDTH-1:0];
                REG_START_X:    start_x_reg  <= cfg_wdata;
                REG_START_Y:    start_y_reg  <= cfg_wdata;
                REG_END_X:      end_x_reg    <= cfg_wdata;
                REG_END_Y:      end_y_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Endpoint offsets from the baseline, refreshed every cycle
    logic signed [TW-1:0] dsx_reg, dsy_reg, dex_reg, dey_reg;

    always_ff @(posedge aclk) begin
        dsx_reg <= $signed({start_x_reg[CW-1], start_x_reg}) - $signed({base_x_reg[CW-1], base_x_reg});
        dsy_reg <= $signed({start_y_reg[CW-1], start_y_reg}) - $signed({base_y_reg[CW-1], base_y_reg});
        dex_reg <= $signed({end_x_reg[CW-1], end_x_reg}) - $signed({base_x_reg[CW-1], base_x_reg});
        dey_reg <= $signed({end_y_reg[CW-1], end_y_reg}) - $signed({base_y_reg[CW-1], base_y_reg});
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    logic            pipe_en;
    logic [NSTG-1:0] vld_reg;
    logic            m_tvalid_reg, skid_valid_reg;
    res_t            out_reg, skid_reg, res_reg;

    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Pose travels beside the arithmetic up to the last stage
    pose_t pose_reg [0:ST_LAST-1];
    pose_t in_pose;

    assign in_pose.pvalid = s_tuser;
    assign in_pose.x      = s_tdata[CW-1:0];
    assign in_pose.y      = s_tdata[2*CW-1:CW];
    assign in_pose.ang    = s_tdata[2*CW+ANGLE_WIDTH-1:2*CW];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pose_reg[0] <= in_pose;
            for (int k = 1; k < ST_LAST; k++) begin
                pose_reg[k] <= pose_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: angle difference wrapped into one turn
    // ------------------------------------------------------------------
    logic signed [ANGLE_WIDTH:0] ang_diff;
    logic [DIFF_WIDTH-1:0]       wrap_v, wrap_sub;
    logic [DEG_WIDTH-1:0]        deg_next, deg0_reg;

    assign ang_diff = $signed({in_pose.ang[ANGLE_WIDTH-1], in_pose.ang})
                    - $signed({base_ang_reg[ANGLE_WIDTH-1], base_ang_reg});
    assign wrap_v   = {ang_diff[ANGLE_WIDTH], ang_diff} + DIFF_WIDTH'(TURN_OFFSET);

    always_comb begin
        wrap_sub = '0;
        for (int m = 1; m <= MAX_WRAPS; m++) begin
            if (wrap_v >= DIFF_WIDTH'(m * TURN_UNITS)) begin
                wrap_sub = DIFF_WIDTH'(m * TURN_UNITS);
            end
        end
        deg_next = DEG_WIDTH'(wrap_v - wrap_sub);
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            deg0_reg <= deg_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-3: degrees to 32-bit binary angle via d = 45*q + r
    // ------------------------------------------------------------------
    logic [RECIP_PROD_WIDTH-1:0] recip1_reg;
    logic [DEG_WIDTH-1:0]        deg1_reg;
    logic [QSEG_WIDTH-1:0]       qseg_next, qseg2_reg;
    logic [REM_WIDTH-1:0]        rem2_reg;
    logic [BAM_WIDTH-1:0]        bam3_reg;

    assign qseg_next = recip1_reg[RECIP_SHIFT+QSEG_WIDTH-1:RECIP_SHIFT];

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            recip1_reg <= RECIP_PROD_WIDTH'(deg0_reg) * RECIP_PROD_WIDTH'(RECIP_SEG);
            deg1_reg   <= deg0_reg;
            qseg2_reg  <= qseg_next;
            rem2_reg   <= REM_WIDTH'(deg1_reg - DEG_WIDTH'(qseg_next) * DEG_WIDTH'(SEG_UNITS));
            bam3_reg   <= {qseg2_reg, seg_bam(rem2_reg)};
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: nearest quadrant removed; stages 5-24: CORDIC rotation
    // ------------------------------------------------------------------
    logic [BAM_WIDTH-1:0]           bam_bias, bam_res;
    quad_t                          quad_next;
    logic signed [CORDIC_WIDTH-1:0] cx_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_WIDTH-1:0] cy_reg [0:CORDIC_STEPS];
    logic signed [CORDIC_WIDTH-1:0] cz_reg [0:CORDIC_STEPS];
    quad_t                          cq_reg [0:CORDIC_STEPS];

    assign bam_bias  = bam3_reg + BAM_WIDTH'(1 << 29);
    assign quad_next = quad_t'(bam_bias[BAM_WIDTH-1:BAM_WIDTH-2]);
    assign bam_res   = bam3_reg - {quad_next, {(BAM_WIDTH-2){1'b0}}};

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cx_reg[0] <= CORDIC_WIDTH'(CORDIC_X0);
            cy_reg[0] <= '0;
            cz_reg[0] <= CORDIC_WIDTH'($signed(bam_res));
            cq_reg[0] <= quad_next;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        logic signed [CORDIC_WIDTH-1:0] x_sh, y_sh;

        assign x_sh = cx_reg[g] >>> g;
        assign y_sh = cy_reg[g] >>> g;

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                if (!cz_reg[g][CORDIC_WIDTH-1]) begin
                    cx_reg[g+1] <= cx_reg[g] - y_sh;
                    cy_reg[g+1] <= cy_reg[g] + x_sh;
                    cz_reg[g+1] <= cz_reg[g] - atan_step(g);
                end else begin
                    cx_reg[g+1] <= cx_reg[g] + y_sh;
                    cy_reg[g+1] <= cy_reg[g] - x_sh;
                    cz_reg[g+1] <= cz_reg[g] + atan_step(g);
                end
                cq_reg[g+1] <= cq_reg[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 25: round to Q1.15 and restore the quadrant
    // ------------------------------------------------------------------
    logic signed [TRIG_WIDTH-1:0] cos_q, sin_q, cos_next, sin_next;
    logic signed [TRIG_WIDTH-1:0] trig_cos_reg, trig_sin_reg;

    assign cos_q = q15_round(cx_reg[CORDIC_STEPS]);
    assign sin_q = q15_round(cy_reg[CORDIC_STEPS]);

    always_comb begin
        case (cq_reg[CORDIC_STEPS])
            QUAD_0: begin
                cos_next = cos_q;
                sin_next = sin_q;
            end
            QUAD_90: begin
                cos_next = -sin_q;
                sin_next = cos_q;
            end
            QUAD_180: begin
                cos_next = -cos_q;
                sin_next = -sin_q;
            end
            default: begin
                cos_next = sin_q;
                sin_next = -cos_q;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            trig_cos_reg <= cos_next;
            trig_sin_reg <= sin_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 26: rotation products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] p_sx_c_reg, p_sy_s_reg, p_sx_s_reg, p_sy_c_reg;
    logic signed [PW-1:0] p_ex_c_reg, p_ey_s_reg, p_ex_s_reg, p_ey_c_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p_sx_c_reg <= dsx_reg * trig_cos_reg;
            p_sy_s_reg <= dsy_reg * trig_sin_reg;
            p_sx_s_reg <= dsx_reg * trig_sin_reg;
            p_sy_c_reg <= dsy_reg * trig_cos_reg;
            p_ex_c_reg <= dex_reg * trig_cos_reg;
            p_ey_s_reg <= dey_reg * trig_sin_reg;
            p_ex_s_reg <= dex_reg * trig_sin_reg;
            p_ey_c_reg <= dey_reg * trig_cos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 27: sum, round and drop the Q15 fraction
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_sx, sum_sy, sum_ex, sum_ey;
    logic signed [RW-1:0] rot_sx_reg, rot_sy_reg, rot_ex_reg, rot_ey_reg;

    assign sum_sx = SW'(p_sx_c_reg) - SW'(p_sy_s_reg) + ROT_HALF;
    assign sum_sy = SW'(p_sx_s_reg) + SW'(p_sy_c_reg) + ROT_HALF;
    assign sum_ex = SW'(p_ex_c_reg) - SW'(p_ey_s_reg) + ROT_HALF;
    assign sum_ey = SW'(p_ex_s_reg) + SW'(p_ey_c_reg) + ROT_HALF;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rot_sx_reg <= sum_sx[SW-1:15];
            rot_sy_reg <= sum_sy[SW-1:15];
            rot_ex_reg <= sum_ex[SW-1:15];
            rot_ey_reg <= sum_ey[SW-1:15];
        end
    end

    // ------------------------------------------------------------------
    // Stage 28: add the current position, saturate, blank a missing pose
    // ------------------------------------------------------------------
    pose_t                pose_fin;
    logic signed [OW-1:0] pos_x, pos_y;
    res_t                 res_next;

    assign pose_fin = pose_reg[ST_LAST-1];
    assign pos_x    = OW'($signed(pose_fin.x));
    assign pos_y    = OW'($signed(pose_fin.y));

    always_comb begin
        res_next = '0;
        if (pose_fin.pvalid) begin
            res_next.sx = sat_coord(pos_x + OW'(rot_sx_reg));
            res_next.sy = sat_coord(pos_y + OW'(rot_sy_reg));
            res_next.ex = sat_coord(pos_x + OW'(rot_ex_reg));
            res_next.ey = sat_coord(pos_y + OW'(rot_ey_reg));
            res_next.px = pose_fin.x;
            res_next.py = pose_fin.y;
            res_next.pa = pose_fin.ang;
        end else begin
            res_next.na = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            res_reg <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    logic pipe_out;

    assign pipe_out = pipe_en && vld_reg[ST_LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg   <= skid_valid_reg || pipe_out;
            skid_valid_reg <= 1'b0;
        end else if (pipe_out) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        end else if (pipe_out) begin
            skid_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.na;
    assign m_tdata  = OUT_DATA_WIDTH'({out_reg.pa, out_reg.py, out_reg.px,
                                       out_reg.ey, out_reg.ex, out_reg.sy, out_reg.sx});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_tvalid_reg)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_out && m_tvalid_reg && !m_tready) |=> skid_valid_reg)
        else $error("beat leaving pipeline during stall not captured in skid");

    a_na_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("not-available beat carries nonzero data");

endmodule
